/* rtl/gfp_pkg.sv */
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared types and constants for the genotype field parser.
// ----------------------------------------------------------------------------
package gfp_pkg;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_AFTER_SEP,
    PH_DIGITS,
    PH_DOT,
    PH_SKIP
  } phase_t;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_EMPTY    = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_EXCEEDS  = 3'd3;
  localparam logic [2:0] ERR_INVALID  = 3'd4;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic ADDR_ALT_COUNT = 1'b0;
  localparam logic ADDR_KNOWN     = 1'b1;

  // control part of one result beat
  typedef struct packed {
    logic       emit;
    logic       missing;
    logic       valid;
    logic [2:0] err;
    logic       last;
  } res_ctl_t;

endpackage

/* rtl/gfp_cfg.sv */
// ----------------------------------------------------------------------------
// gfp_cfg
// APB register block: alternate allele count and the index check enable.
// ----------------------------------------------------------------------------
module gfp_cfg #(
  parameter int ALT_COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [ALT_COUNT_BITS-1:0] alt_count,
  output logic                      alleles_known
);
  import gfp_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // word aligned: bit 2 picks the register
  always_ff @(posedge clk) begin
    if (rst) begin
      alt_count     <= '0;
      alleles_known <= 1'b0;
    end else if (wr) begin
      if (paddr[2] == ADDR_ALT_COUNT) begin
        alt_count <= pwdata[ALT_COUNT_BITS-1:0];
      end else begin
        alleles_known <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_KNOWN) begin
      prdata = {31'd0, alleles_known};
    end else begin
      prdata = 32'(alt_count);
    end
  end

endmodule

/* rtl/gfp_parse.sv */
// ----------------------------------------------------------------------------
// gfp_parse
// Per-character step: next parser state and the result beat, if any.
// ----------------------------------------------------------------------------
module gfp_parse #(
  parameter int ALLELE_BITS    = 32,
  parameter int ALT_COUNT_BITS = 16
) (
  input  gfp_pkg::phase_t           phase,
  input  logic [ALLELE_BITS-1:0]    acc,
  input  logic                      flag,
  input  logic [7:0]                char_code,
  input  logic                      end_of_token,
  input  logic [ALT_COUNT_BITS-1:0] alt_count,
  input  logic                      alleles_known,
  output gfp_pkg::phase_t           phase_next,
  output logic [ALLELE_BITS-1:0]    acc_next,
  output logic                      flag_next,
  output gfp_pkg::res_ctl_t         res,
  output logic [ALLELE_BITS-1:0]    res_index
);
  import gfp_pkg::*;

  localparam int CW = (ALLELE_BITS > ALT_COUNT_BITS) ? ALLELE_BITS : ALT_COUNT_BITS;
  localparam logic [ALLELE_BITS-1:0] MAX       = '1;
  localparam logic [ALLELE_BITS-1:0] MAX_DIV10 = MAX / 10;
  localparam logic [3:0]             MAX_MOD10 = 4'(MAX % 10);

  logic                   is_digit;
  logic                   is_sep;
  logic [3:0]             digit;
  logic                   too_big;
  logic                   ovf;
  logic [ALLELE_BITS-1:0] acc_x10;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_sep   = (char_code == CH_SLASH) || (char_code == CH_BAR);
  assign digit    = 4'(char_code - CH_ZERO);
  assign too_big  = alleles_known && (CW'(acc) > CW'(alt_count));
  assign ovf      = (acc > MAX_DIV10) || ((acc == MAX_DIV10) && (digit > MAX_MOD10));
  assign acc_x10  = (acc << 3) + (acc << 1) + ALLELE_BITS'(digit);

  always_comb begin
    phase_next  = phase;
    acc_next    = acc;
    flag_next   = flag;
    res         = '0;
    res.err     = ERR_OK;
    res_index   = '0;

    if (end_of_token) begin
      phase_next = PH_FIRST;
      acc_next   = '0;
      case (phase)
        PH_FIRST: begin
          res.emit = 1'b1;
          res.err  = ERR_EMPTY;
          res.last = 1'b1;
        end
        PH_AFTER_SEP: begin
          res.emit = 1'b1;
          res.err  = ERR_INVALID;
          res.last = 1'b1;
        end
        PH_DIGITS: begin
          res.emit  = 1'b1;
          res.valid = 1'b1;
          res.last  = 1'b1;
          res_index = acc;
          if (too_big) res.err = ERR_EXCEEDS;
        end
        PH_DOT: begin
          res.emit    = 1'b1;
          res.valid   = 1'b1;
          res.missing = 1'b1;
          res.last    = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (phase)
        PH_FIRST, PH_AFTER_SEP: begin
          if (char_code == CH_DOT) begin
            phase_next = PH_DOT;
          end else if (is_digit) begin
            phase_next = PH_DIGITS;
            acc_next   = ALLELE_BITS'(digit);
          end else begin
            phase_next = PH_SKIP;
            acc_next   = '0;
            res.emit   = 1'b1;
            res.err    = ERR_INVALID;
            res.last   = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (ovf) begin
              phase_next = PH_SKIP;
              acc_next   = '0;
              res.emit   = 1'b1;
              res.err    = ERR_OVERFLOW;
              res.last   = 1'b1;
            end else begin
              acc_next = acc_x10;
            end
          end else if (too_big) begin
            // index check comes before the character check
            phase_next = PH_SKIP;
            acc_next   = '0;
            res.emit   = 1'b1;
            res.valid  = 1'b1;
            res.err    = ERR_EXCEEDS;
            res.last   = 1'b1;
            res_index  = acc;
          end else if (!is_sep) begin
            phase_next = PH_SKIP;
            acc_next   = '0;
            res.emit   = 1'b1;
            res.err    = ERR_INVALID;
            res.last   = 1'b1;
          end else begin
            flag_next  = (char_code == CH_BAR);
            phase_next = PH_AFTER_SEP;
            acc_next   = '0;
            res.emit   = 1'b1;
            res.valid  = 1'b1;
            res_index  = acc;
          end
        end
        PH_DOT: begin
          if (!is_sep) begin
            phase_next = PH_SKIP;
            acc_next   = '0;
            res.emit   = 1'b1;
            res.err    = ERR_INVALID;
            res.last   = 1'b1;
          end else begin
            flag_next   = (char_code == CH_BAR);
            phase_next  = PH_AFTER_SEP;
            acc_next    = '0;
            res.emit    = 1'b1;
            res.valid   = 1'b1;
            res.missing = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/genotype_field_parser_unit.sv */
// ----------------------------------------------------------------------------
// genotype_field_parser_unit
// Streaming parser for a genotype token, one character per beat.
// ----------------------------------------------------------------------------
// Takes one character (or an end-of-token marker) per clock and gives at most
// one allele beat per input beat, which passes through two registers: the input
// register, then the result register. The per-character update
// (compare, multiply by ten as shift-and-add, add digit) sits between those two
// registers, so a new beat is taken every cycle for as long as the output side
// is not stalled. Configure alt_count and alleles_known over APB while idle.
module genotype_field_parser_unit #(
  parameter int ALLELE_BITS    = 32,
  parameter int ALT_COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // APB
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // character input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             char_code,
  input  logic                   end_of_token,
  // allele output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ALLELE_BITS-1:0] allele_index,
  output logic                   allele_missing,
  output logic                   allele_valid,
  output logic                   phased,
  output logic [2:0]             error_code,
  output logic                   last
);
  import gfp_pkg::*;

  logic [ALT_COUNT_BITS-1:0] alt_count;
  logic                      alleles_known;

  logic                      in_full;
  logic [7:0]                char_q;
  logic                      eot_q;
  logic                      advance;
  logic                      take;

  phase_t                    phase;
  phase_t                    phase_next;
  logic [ALLELE_BITS-1:0]    acc;
  logic [ALLELE_BITS-1:0]    acc_next;
  logic                      flag;
  logic                      flag_next;
  res_ctl_t                  res;
  logic [ALLELE_BITS-1:0]    res_index;

  gfp_cfg #(
    .ALT_COUNT_BITS(ALT_COUNT_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .alt_count    (alt_count),
    .alleles_known(alleles_known)
  );

  gfp_parse #(
    .ALLELE_BITS   (ALLELE_BITS),
    .ALT_COUNT_BITS(ALT_COUNT_BITS)
  ) u_parse (
    .phase        (phase),
    .acc          (acc),
    .flag         (flag),
    .char_code    (char_q),
    .end_of_token (eot_q),
    .alt_count    (alt_count),
    .alleles_known(alleles_known),
    .phase_next   (phase_next),
    .acc_next     (acc_next),
    .flag_next    (flag_next),
    .res          (res),
    .res_index    (res_index)
  );

  // held beat moves on when the result register is free or being drained
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char_q <= char_code;
      eot_q  <= end_of_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      acc   <= '0;
      flag  <= 1'b0;
    end else if (in_full && advance) begin
      phase <= phase_next;
      acc   <= acc_next;
      flag  <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_full && advance && res.emit) begin
      allele_index   <= res_index;
      allele_missing <= res.missing;
      allele_valid   <= res.valid;
      phased         <= flag_next;
      error_code     <= res.err;
      last           <= res.last;
    end
  end

endmodule

/* tb/tb_genotype_field_parser_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_genotype_field_parser_unit
// Self-checking bench for the genotype token parser.
// ----------------------------------------------------------------------------
// A short table of hand-picked tokens runs first at reset settings. Random
// tokens follow under four alt_count / alleles_known settings, including both
// extremes of alt_count. Every accepted character is fed to a behavioural
// model of the parser and every allele beat is compared field by field.
// Both sides stall in random bursts. The closing stretch runs without gaps.
// ----------------------------------------------------------------------------
module tb_genotype_field_parser_unit;
  import gfp_pkg::*;

  typedef struct packed {
    logic [31:0] idx;
    logic        miss;
    logic        vld;
    logic        ph;
    logic [2:0]  err;
    logic        lst;
  } allele_beat_t;

  typedef struct {
    logic [7:0]   c;
    logic         e;
    bit           typed;
    allele_beat_t want;
  } stim_row_t;

  localparam logic [31:0] IDX_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] IDX_DIV10 = IDX_MAX / 10;
  localparam logic [31:0] IDX_MOD10 = IDX_MAX % 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = '0;
  logic        end_of_token = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] allele_index;
  logic        allele_missing;
  logic        allele_valid;
  logic        phased;
  logic [2:0]  error_code;
  logic        last;

  // parser model state and its copy of the registers
  phase_t      gt_phase = PH_FIRST;
  logic [31:0] gt_acc = '0;
  logic        gt_phased = 1'b0;
  logic [15:0] alt_count_reg = '0;
  logic        known_reg = 1'b0;

  allele_beat_t pending_alleles[$];
  stim_row_t    dir_tab[$];
  logic [7:0]   tok_chars[$];

  bit jitter_on = 1'b1;
  int stall_left = 0;
  int beats_sent = 0;
  int tokens = 0;
  int alleles_checked = 0;
  int mismatches = 0;

  genotype_field_parser_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .char_code(char_code), .end_of_token(end_of_token),
    .out_valid(out_valid), .out_stall(out_stall),
    .allele_index(allele_index), .allele_missing(allele_missing),
    .allele_valid(allele_valid), .phased(phased),
    .error_code(error_code), .last(last)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic void put_char(logic [7:0] c);
    tok_chars.insert(tok_chars.size(), c);
  endfunction

  function automatic void hold_result(allele_beat_t b);
    pending_alleles.insert(pending_alleles.size(), b);
  endfunction

  function automatic allele_beat_t mk(logic [31:0] i, logic m, logic v, logic p,
                                      logic [2:0] er, logic l);
    return '{i, m, v, p, er, l};
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic e,
                             output bit has, output allele_beat_t r);
    logic       is_digit;
    logic       is_sep;
    logic       over;
    logic [3:0] dig;
    phase_t     ph;
    logic [31:0] acc;
    is_digit = c >= CH_ZERO && c <= CH_NINE;
    is_sep   = c == CH_SLASH || c == CH_BAR;
    dig      = 4'(c - CH_ZERO);
    ph       = gt_phase;
    acc      = gt_acc;
    over     = known_reg && acc > {16'd0, alt_count_reg};
    has      = 1'b0;
    r        = '0;
    if (e) begin
      gt_phase = PH_FIRST;
      gt_acc   = '0;
      has      = ph != PH_SKIP;
      case (ph)
        PH_FIRST:     r = mk('0, 1'b0, 1'b0, gt_phased, ERR_EMPTY, 1'b1);
        PH_AFTER_SEP: r = mk('0, 1'b0, 1'b0, gt_phased, ERR_INVALID, 1'b1);
        PH_DIGITS:    r = mk(acc, 1'b0, 1'b1, gt_phased, over ? ERR_EXCEEDS : ERR_OK, 1'b1);
        PH_DOT:       r = mk('0, 1'b1, 1'b1, gt_phased, ERR_OK, 1'b1);
        default:      r = '0;
      endcase
    end else begin
      case (ph)
        PH_FIRST, PH_AFTER_SEP: begin
          if (c == CH_DOT) begin
            gt_phase = PH_DOT;
          end else if (is_digit) begin
            gt_acc   = {28'd0, dig};
            gt_phase = PH_DIGITS;
          end else begin
            gt_phase = PH_SKIP;
            has      = 1'b1;
            r        = mk('0, 1'b0, 1'b0, gt_phased, ERR_INVALID, 1'b1);
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (acc > IDX_DIV10 || (acc == IDX_DIV10 && dig > IDX_MOD10)) begin
              gt_phase = PH_SKIP;
              gt_acc   = '0;
              has      = 1'b1;
              r        = mk('0, 1'b0, 1'b0, gt_phased, ERR_OVERFLOW, 1'b1);
            end else begin
              gt_acc = acc * 10 + dig;
            end
          end else begin
            // the index check wins over the character check
            gt_acc = '0;
            has    = 1'b1;
            if (over) begin
              gt_phase = PH_SKIP;
              r        = mk(acc, 1'b0, 1'b1, gt_phased, ERR_EXCEEDS, 1'b1);
            end else if (!is_sep) begin
              gt_phase = PH_SKIP;
              r        = mk('0, 1'b0, 1'b0, gt_phased, ERR_INVALID, 1'b1);
            end else begin
              gt_phased = c == CH_BAR;
              gt_phase  = PH_AFTER_SEP;
              r         = mk(acc, 1'b0, 1'b1, gt_phased, ERR_OK, 1'b0);
            end
          end
        end
        PH_DOT: begin
          gt_acc = '0;
          has    = 1'b1;
          if (!is_sep) begin
            gt_phase = PH_SKIP;
            r        = mk('0, 1'b0, 1'b0, gt_phased, ERR_INVALID, 1'b1);
          end else begin
            gt_phased = c == CH_BAR;
            gt_phase  = PH_AFTER_SEP;
            r         = mk('0, 1'b1, 1'b1, gt_phased, ERR_OK, 1'b0);
          end
        end
        default: has = 1'b0;
      endcase
    end
  endtask

  // -------------------------------------------------------------- driving

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(input logic [7:0] c, input logic e, input bit typed = 1'b0,
                           input allele_beat_t want = '0);
    bit           has;
    allele_beat_t r;
    if (jitter_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= c;
    end_of_token <= e;
    do @(posedge clk); while (in_stall);
    decode_char(c, e, has, r);
    if (typed) hold_result(want);
    else if (has) hold_result(r);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_alleles.size() != 0);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_number(input longint unsigned v, input bit lead0);
    logic [7:0] digs[$];
    if (lead0) repeat ($urandom_range(1, 2)) put_char(CH_ZERO);
    do begin
      digs.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) put_char(digs[i]);
  endtask

  task automatic add_alleles();
    longint unsigned v;
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) put_char($urandom_range(0, 1) ? CH_BAR : CH_SLASH);
      case ($urandom_range(0, 9))
        0, 1: put_char(CH_DOT);
        2, 3: push_number($urandom_range(0, 9), $urandom_range(0, 7) == 0);
        4, 5: begin
          // straddle the alt_count limit
          v = alt_count_reg + $urandom_range(0, 2);
          if (v != 0) v--;
          push_number(v, $urandom_range(0, 7) == 0);
        end
        6, 7: push_number($urandom, $urandom_range(0, 7) == 0);
        8:    push_number(64'd4294967290 + $urandom_range(0, 10), 1'b0);
        default: push_number({$urandom, $urandom}, 1'b0);
      endcase
    end
  endtask

  task automatic make_token();
    string alph;
    alph = "0123456789./|";
    tok_chars.delete();
    if ($urandom_range(0, 99) < 80) begin
      add_alleles();
    end else begin
      case ($urandom_range(0, 4))
        0: ;  // empty token
        1: begin
          add_alleles();
          put_char($urandom_range(0, 1) ? CH_BAR : CH_SLASH);
        end
        2: repeat ($urandom_range(1, 5)) put_char(8'($urandom_range(0, 255)));
        3: repeat ($urandom_range(1, 6)) put_char(alph[$urandom_range(0, 12)]);
        default: begin
          add_alleles();
          put_char(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  task automatic run_phase(input logic [15:0] alt, input logic known, input int n_beats,
                           input bit calm_tail);
    int first;
    drain_results();
    repeat (8) @(posedge clk);  // let beats that give no result clear the pipe
    apb_write({ADDR_ALT_COUNT, 2'b00}, {16'd0, alt});
    alt_count_reg = alt;
    apb_write({ADDR_KNOWN, 2'b00}, {31'd0, known});
    known_reg = known;
    first = beats_sent;
    while (beats_sent - first < n_beats) begin
      if (calm_tail && beats_sent - first >= n_beats / 2) jitter_on = 1'b0;
      else jitter_on = $urandom_range(0, 4) != 0;
      if (tokens % 25 == 7 || $urandom_range(0, 39) == 0) drain_results();
      make_token();
      foreach (tok_chars[i]) send_beat(tok_chars[i], 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      tokens++;
    end
  endtask

  // ------------------------------------------------------------- stimulus

  function automatic void add_row(logic [7:0] c, logic e, bit typed = 1'b0,
                                  allele_beat_t want = '0);
    stim_row_t row;
    row = '{c, e, typed, want};
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  initial begin
    string big;
    big = "4294967296";
    add_row(8'h00, 1'b1, 1'b1, mk('0, 1'b0, 1'b0, 1'b0, ERR_EMPTY, 1'b1));
    add_row(8'hFF, 1'b0, 1'b1, mk('0, 1'b0, 1'b0, 1'b0, ERR_INVALID, 1'b1));
    add_row(CH_SLASH, 1'b1);
    add_row(CH_DOT, 1'b0);
    add_row(CH_BAR, 1'b0, 1'b1, mk('0, 1'b1, 1'b1, 1'b1, ERR_OK, 1'b0));
    // end straight after a separator
    add_row(8'h00, 1'b1, 1'b1, mk('0, 1'b0, 1'b0, 1'b1, ERR_INVALID, 1'b1));
    add_row(CH_DOT, 1'b0);
    add_row("7", 1'b0, 1'b1, mk('0, 1'b0, 1'b0, 1'b1, ERR_INVALID, 1'b1));
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b1);
    add_row(CH_ZERO, 1'b0);
    add_row(CH_SLASH, 1'b0, 1'b1, mk('0, 1'b0, 1'b1, 1'b0, ERR_OK, 1'b0));
    add_row(CH_DOT, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, mk('0, 1'b1, 1'b1, 1'b0, ERR_OK, 1'b1));
    // one past the largest index: overflow on the tenth digit
    for (int i = 0; i < big.len(); i++)
      add_row(big[i], 1'b0, i == big.len() - 1,
              mk('0, 1'b0, 1'b0, 1'b0, ERR_OVERFLOW, 1'b1));
    add_row(CH_NINE, 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i])
      send_beat(dir_tab[i].c, dir_tab[i].e, dir_tab[i].typed, dir_tab[i].want);

    run_phase(16'd0, 1'b1, 256, 1'b0);
    run_phase(16'hFFFF, 1'b1, 256, 1'b0);
    run_phase(16'($urandom_range(1, 6)), 1'b1, 256, 1'b0);
    run_phase(16'($urandom_range(0, 65535)), 1'b0, 256, 1'b1);

    drain_results();
    repeat (10) @(posedge clk);
    $display("%0d beats in %0d tokens, %0d allele beats checked, %0d mismatches",
             beats_sent, tokens, alleles_checked, mismatches);
    $display("settings: reset, alt_count 0 and 65535 checked, small limit, check off");
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------- output

  always @(posedge clk) begin
    if (rst || !jitter_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 15) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    allele_beat_t exp_b;
    if (!rst && out_valid && !out_stall) begin
      if (pending_alleles.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected beat, expected none, got index %0h err %0d",
                   $time, allele_index, error_code);
      end else begin
        exp_b = pending_alleles.pop_front();
        alleles_checked++;
        check_field("allele_index", exp_b.idx, allele_index);
        check_field("allele_missing", {31'd0, exp_b.miss}, {31'd0, allele_missing});
        check_field("allele_valid", {31'd0, exp_b.vld}, {31'd0, allele_valid});
        check_field("phased", {31'd0, exp_b.ph}, {31'd0, phased});
        check_field("error_code", {29'd0, exp_b.err}, {29'd0, error_code});
        check_field("last", {31'd0, exp_b.lst}, {31'd0, last});
      end
    end
  end

endmodule
